/* rtl/psched_pkg.sv */
// ----------------------------------------------------------------------------
// psched_pkg
// shared types and constants of the priority task scheduler
// ----------------------------------------------------------------------------
package psched_pkg;

  localparam int TASK_COUNT_DEF = 8;
  localparam int TICK_W         = 24;
  localparam int SEM_W          = 8;
  localparam int START_W        = 3;
  localparam int TASK_W_OUT     = 4;
  localparam int MAP_W_OUT      = 9;

  localparam logic [SEM_W-1:0] SEM_NONE = 8'hFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DELAY = 2'd1,
    OP_PEND  = 2'd2,
    OP_POST  = 2'd3
  } psched_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } psched_state_e;

  // one kernel operation as captured at the input beat
  typedef struct packed {
    psched_op_e               op;
    logic [SEM_W-1:0]         sem;
    logic signed [TICK_W-1:0] ticks;
    logic                     irq;
  } psched_cmd_t;

  // per-task record
  typedef struct packed {
    logic signed [TICK_W-1:0] wait_cnt;
    logic [SEM_W-1:0]         sem;
    logic                     owns;
  } psched_entry_t;

endpackage

/* rtl/psched_entry_unit.sv */
// ----------------------------------------------------------------------------
// psched_entry_unit
// shared update unit applied to one task record per cycle
// ----------------------------------------------------------------------------
module psched_entry_unit (
  input  psched_pkg::psched_cmd_t   cmd_i,
  input  logic                      is_running_i,
  input  psched_pkg::psched_entry_t entry_i,
  input  logic                      ready_i,
  output psched_pkg::psched_entry_t entry_o,
  output logic                      ready_o,
  output logic                      tick_hit_o
);
  import psched_pkg::*;

  always_comb begin
    entry_o    = entry_i;
    ready_o    = ready_i;
    tick_hit_o = 1'b0;
    unique case (cmd_i.op)
      OP_TICK: begin
        if (entry_i.wait_cnt > $signed(TICK_W'(0))) begin
          entry_o.wait_cnt = entry_i.wait_cnt - $signed(TICK_W'(1));
        end
        if (entry_o.wait_cnt == $signed(TICK_W'(0))) begin
          ready_o    = 1'b1;
          tick_hit_o = 1'b1;
        end
      end
      OP_DELAY, OP_PEND: begin
        if (!cmd_i.irq && is_running_i) begin
          entry_o.owns     = 1'b0;
          entry_o.wait_cnt = cmd_i.ticks;
          ready_o          = 1'b0;
          if (cmd_i.op == OP_PEND) begin
            entry_o.sem = cmd_i.sem;
          end
        end
      end
      OP_POST: begin
        if (cmd_i.sem != SEM_NONE) begin
          if (is_running_i) begin
            // poster gives up its event and stops pending
            entry_o.owns = 1'b0;
            entry_o.sem  = SEM_NONE;
          end else if (entry_i.sem == cmd_i.sem) begin
            entry_o.sem      = SEM_NONE;
            entry_o.owns     = 1'b1;
            entry_o.wait_cnt = '0;
            ready_o          = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/psched_task_store.sv */
// ----------------------------------------------------------------------------
// psched_task_store
// per-task records, read and written at the walk index
// ----------------------------------------------------------------------------
module psched_task_store #(
  parameter  int TASK_COUNT = psched_pkg::TASK_COUNT_DEF,
  localparam int IW         = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [IW-1:0]             idx_i,
  input  logic                      we_i,
  input  psched_pkg::psched_entry_t wdata_i,
  output psched_pkg::psched_entry_t rdata_o
);
  import psched_pkg::*;

  psched_entry_t entry_q [TASK_COUNT];

  assign rdata_o = entry_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TASK_COUNT; k++) begin
        entry_q[k].wait_cnt <= '0;
        entry_q[k].sem      <= SEM_NONE;
        entry_q[k].owns     <= 1'b0;
      end
    end else if (we_i) begin
      entry_q[idx_i] <= wdata_i;
    end
  end

endmodule

/* rtl/priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_task_scheduler
// bitmap priority scheduler for a small real-time kernel
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o   | opcode, sem_id, wait_ticks, irq
//  out     | output    | out_valid_o / out_stall_i | switch_now, prev/next task, map
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (start_task)
//
//  each item walks the task records through the shared entry unit, one task
//  record per cycle, then a finishing state makes the pick and loads the
//  output, then the block returns to idle; input is stalled until it is back
//  in idle, and the result is registered as the finishing state is left
//  reset is asynchronous, active low; all task records take their reset values
//  at once, running task is task 0
//  a stalled output holds the block in its finishing cycle until taken
//
module priority_task_scheduler #(
  parameter int TASK_COUNT = psched_pkg::TASK_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [psched_pkg::START_W-1:0]       cfg_wdata_i,
  // operation beats
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           opcode_i,
  input  logic [psched_pkg::SEM_W-1:0]         sem_id_i,
  input  logic signed [psched_pkg::TICK_W-1:0] wait_ticks_i,
  input  logic                                 from_interrupt_i,
  // result beats
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 switch_now_o,
  output logic [psched_pkg::TASK_W_OUT-1:0]    prev_task_o,
  output logic [psched_pkg::TASK_W_OUT-1:0]    next_task_o,
  output logic [psched_pkg::MAP_W_OUT-1:0]     ready_map_o
);
  import psched_pkg::*;

  localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int RW = $clog2(TASK_COUNT + 1);
  localparam int NB = TASK_COUNT + 1;   // tasks plus idle slot

  localparam logic [IW-1:0] LAST_IDX  = IW'(TASK_COUNT - 1);
  localparam logic [RW-1:0] IDLE_SLOT = RW'(TASK_COUNT);

  // control state
  psched_state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [NB-1:0] ready_q, ready_d;
  logic [RW-1:0] running_q, running_d;
  logic [START_W-1:0] start_q, start_d;
  logic          found_q, found_d;
  logic [RW-1:0] best_q, best_d;
  logic          resched_q, resched_d;
  logic          run_owns_q, run_owns_d;
  logic          out_valid_q, out_valid_d;

  // payload
  psched_cmd_t   cmd_q, cmd_d;
  logic          sw_q, sw_d;
  logic [TASK_W_OUT-1:0] prev_q, prev_d;
  logic [TASK_W_OUT-1:0] next_q, next_d;
  logic [MAP_W_OUT-1:0]  map_q, map_d;

  // shared unit hookup
  psched_entry_t ent_rd, ent_wr;
  logic          is_running;
  logic          ready_new;
  logic          tick_hit;
  logic          store_we;

  // widened views for masking to the port widths
  logic [31:0]   cur_wide, pick_wide, map_wide;
  logic [RW-1:0] pick;
  logic          do_pick;
  logic          do_switch;
  logic [RW-1:0] cfg_slot;

  assign is_running = (RW'(idx_q) == running_q);

  psched_task_store #(
    .TASK_COUNT (TASK_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (idx_q),
    .we_i    (store_we),
    .wdata_i (ent_wr),
    .rdata_o (ent_rd)
  );

  psched_entry_unit u_unit (
    .cmd_i        (cmd_q),
    .is_running_i (is_running),
    .entry_i      (ent_rd),
    .ready_i      (ready_q[idx_q]),
    .entry_o      (ent_wr),
    .ready_o      (ready_new),
    .tick_hit_o   (tick_hit)
  );

  // a start task out of range selects the idle slot
  assign cfg_slot = (32'(cfg_wdata_i) < TASK_COUNT) ? RW'(cfg_wdata_i) : IDLE_SLOT;

  // idle bit is always set, so no hit in the walk means idle
  assign pick = found_q ? best_q : IDLE_SLOT;

  // tick picks only if some task came due; handler context never picks for delay, pend or post
  always_comb begin
    unique case (cmd_q.op)
      OP_TICK:                   do_pick = resched_q;
      OP_DELAY, OP_PEND, OP_POST: do_pick = !cmd_q.irq;
      default:                   do_pick = 1'b0;
    endcase
  end

  // a running task that owns an event keeps the cpu
  assign do_switch = do_pick && (pick != running_q)
                   && !((running_q < IDLE_SLOT) && run_owns_q);

  assign cur_wide  = 32'(running_q);
  assign pick_wide = 32'(do_switch ? pick : running_q);
  assign map_wide  = 32'(ready_q);

  assign store_we   = (state_q == ST_WALK);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ready_d     = ready_q;
    running_d   = running_q;
    start_d     = start_q;
    found_d     = found_q;
    best_d      = best_q;
    resched_d   = resched_q;
    run_owns_d  = run_owns_q;
    cmd_d       = cmd_q;
    sw_d        = sw_q;
    prev_d      = prev_q;
    next_d      = next_q;
    map_d       = map_q;
    out_valid_d = out_valid_q && out_stall_i;

    // config must only arrive while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      start_d   = cfg_wdata_i;
      running_d = cfg_slot;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d.op    = psched_op_e'(opcode_i);
          cmd_d.sem   = sem_id_i;
          cmd_d.ticks = wait_ticks_i;
          cmd_d.irq   = from_interrupt_i;
          idx_d       = '0;
          found_d     = 1'b0;
          resched_d   = 1'b0;
          run_owns_d  = 1'b0;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        // this entry's ready bit is final once processed
        ready_d[idx_q] = ready_new;
        if (tick_hit) begin
          resched_d = 1'b1;
        end
        if (is_running) begin
          run_owns_d = ent_wr.owns;
        end
        if (!found_q && ready_new) begin
          found_d = 1'b1;
          best_d  = RW'(idx_q);
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          sw_d        = do_switch;
          prev_d      = cur_wide[TASK_W_OUT-1:0];
          next_d      = pick_wide[TASK_W_OUT-1:0];
          map_d       = map_wide[MAP_W_OUT-1:0];
          out_valid_d = 1'b1;
          if (do_switch) begin
            running_d = pick;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      ready_q     <= '1;
      running_q   <= '0;
      start_q     <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      resched_q   <= 1'b0;
      run_owns_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ready_q     <= ready_d;
      running_q   <= running_d;
      start_q     <= start_d;
      found_q     <= found_d;
      best_q      <= best_d;
      resched_q   <= resched_d;
      run_owns_q  <= run_owns_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    sw_q   <= sw_d;
    prev_q <= prev_d;
    next_q <= next_d;
    map_q  <= map_d;
  end

  assign out_valid_o  = out_valid_q;
  assign switch_now_o = sw_q;
  assign prev_task_o  = prev_q;
  assign next_task_o  = next_q;
  assign ready_map_o  = map_q;

endmodule

/* rtl/psched_checker.sv */
// ----------------------------------------------------------------------------
// psched_checker
// port-level checks of the priority task scheduler
// ----------------------------------------------------------------------------
module psched_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 switch_now_o,
  input logic [psched_pkg::TASK_W_OUT-1:0]    prev_task_o,
  input logic [psched_pkg::TASK_W_OUT-1:0]    next_task_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // after an input beat the block is busy walking the task records
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  // no switch means the running task stays
  a_no_switch_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !switch_now_o |-> next_task_o == prev_task_o)
    else $error("task changed without a switch");

  // a switch always goes to another task
  a_switch_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switch_now_o |-> next_task_o != prev_task_o)
    else $error("switch to the same task");

endmodule

bind priority_task_scheduler psched_checker u_psched_checker (.*);
